@@ hw/rtl/gcwh_pkg.sv @@
// types, constants and helper functions shared by the gated contrast / hsv block
`default_nettype none

package gcwh_pkg;

	// field widths
	localparam int unsigned CH_W      = 8;
	localparam int unsigned GAIN_W    = 10;
	localparam int unsigned HUE_W     = 9;
	localparam int unsigned HNUM_W    = 17;
	localparam int unsigned SNUM_W    = 16;
	localparam int unsigned PROD_W    = 20;
	localparam int unsigned SUM_W     = PROD_W + 1;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = GAIN_W;

	// pipeline shape: front stages, then one divider stage per quotient bit
	localparam int unsigned FRONT_STAGES = 5;
	localparam int unsigned QUO_W        = HUE_W;
	localparam int unsigned NUM_STAGES   = FRONT_STAGES + QUO_W;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RST   = 10'd384;
	localparam logic [CH_W-1:0]   THRESH_RST = 8'd51;

	// stretch offset, 255 * 256, and channel full scale
	localparam logic signed [SUM_W-1:0] STRETCH_OFS = 21'sd65280;
	localparam logic [CH_W-1:0]         CH_MAX      = 8'd255;

	// hue sector bases in degrees and the slope per sector
	localparam logic [HUE_W-1:0]          HUE_BASE_RED   = 9'd0;
	localparam logic [HUE_W-1:0]          HUE_BASE_WRAP  = 9'd360;
	localparam logic [HUE_W-1:0]          HUE_BASE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0]          HUE_BASE_BLUE  = 9'd240;
	localparam logic signed [HNUM_W:0]    HUE_STEP       = 18'sd60;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 1'b0,
		CFG_THRESH = 1'b1
	} cfg_idx_t;

	// which channel holds the max, and whether the red angle wraps
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_RED_WRAP,
		SEC_GREEN,
		SEC_BLUE
	} hsec_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	// operands of the two dividers
	typedef struct packed {
		logic [HNUM_W-1:0] hue_num;
		logic [CH_W-1:0]   hue_den;
		logic [SNUM_W-1:0] sat_num;
		logic [CH_W-1:0]   sat_den;
	} divop_t;

	typedef struct packed {
		rgb_t               pix;
		logic [CH_W-1:0]    mx;
		logic [CH_W-1:0]    delta;
		hsec_t              sec;
		logic signed [CH_W:0] diff;
	} s1_t;

	typedef struct packed {
		rgb_t                    pix;
		logic [CH_W-1:0]         mx;
		logic                    gate;
		divop_t                  dop;
		logic signed [PROD_W-1:0] prod_r;
		logic signed [PROD_W-1:0] prod_g;
		logic signed [PROD_W-1:0] prod_b;
	} s2_t;

	typedef struct packed {
		rgb_t            pix;
		logic [CH_W-1:0] mx;
		divop_t          dop;
		rgb_t            con;
	} s3_t;

	typedef struct packed {
		logic [CH_W-1:0]   mx;
		divop_t            dop;
		rgb_t              con;
		logic [2*CH_W-1:0] mul_r;
		logic [2*CH_W-1:0] mul_g;
		logic [2*CH_W-1:0] mul_b;
	} s4_t;

	// results that ride alongside the dividers
	typedef struct packed {
		rgb_t            con;
		rgb_t            bld;
		logic [CH_W-1:0] mx;
	} side_t;

	typedef struct packed {
		side_t  side;
		divop_t dop;
	} s5_t;

	// offset, floor divide by 512 and clamp of one stretch product
	function automatic logic [CH_W-1:0] stretch_clamp(input logic signed [PROD_W-1:0] prod);
		logic signed [SUM_W-1:0] sum;
		logic [SUM_W-11:0]       quo;
		logic [CH_W-1:0]         res;
		sum = SUM_W'(prod) + STRETCH_OFS;
		quo = sum[SUM_W-2:9];
		if (sum[SUM_W-1]) begin
			res = '0;
		end else if (quo > (SUM_W-10)'(CH_MAX)) begin
			res = CH_MAX;
		end else begin
			res = quo[CH_W-1:0];
		end
		return res;
	endfunction

	// floor(p / 255) for p up to 255 * 255
	function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
		logic [2*CH_W:0] t;
		t = (2*CH_W+1)'(p) + (2*CH_W+1)'(p >> CH_W) + (2*CH_W+1)'(1);
		return t[2*CH_W-1:CH_W];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gcwh_pix_if.sv @@
// pixel input channel: valid/ready with the three channel codes
`default_nettype none

interface gcwh_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gcwh_res_if.sv @@
// result channel: valid/ready with contrast, blend and hsv fields
`default_nettype none

interface gcwh_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] contrast_red;
	logic [7:0] contrast_green;
	logic [7:0] contrast_blue;
	logic [7:0] blend_red;
	logic [7:0] blend_green;
	logic [7:0] blend_blue;
	logic [8:0] hue;
	logic [7:0] saturation;
	logic [7:0] value_level;

	modport source (
		output valid, input ready,
		output contrast_red, output contrast_green, output contrast_blue,
		output blend_red, output blend_green, output blend_blue,
		output hue, output saturation, output value_level
	);
	modport sink (
		input valid, output ready,
		input contrast_red, input contrast_green, input contrast_blue,
		input blend_red, input blend_green, input blend_blue,
		input hue, input saturation, input value_level
	);
endinterface

`default_nettype wire

@@ hw/rtl/gcwh_div.sv @@
// pipelined restoring divider, one quotient bit per stage with per-stage enable
`default_nettype none

module gcwh_div #(
	parameter int unsigned NUM_W = 17,
	parameter int unsigned DEN_W = 8,
	parameter int unsigned QUO_W = 9
) (
	input  wire logic             clk,
	input  wire logic [QUO_W-1:0] en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	localparam int unsigned SH_W  = DEN_W + QUO_W;
	localparam int unsigned CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [CMP_W-1:0] shifted;
		logic [CMP_W-1:0] rem_ext;
		logic [CMP_W-1:0] rem_sub;
		logic             take;
		logic [QUO_W-1:0] quo_nxt;

		// operands from the previous stage, or from the input for the first
		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// trial subtract of the divisor aligned to this quotient bit
		always_comb begin
			shifted = CMP_W'(den_in) << (QUO_W - 1 - k);
			rem_ext = CMP_W'(rem_in);
			take    = (shifted <= rem_ext);
			rem_sub = rem_ext - shifted;
			quo_nxt = quo_in;
			quo_nxt[QUO_W-1-k] = take;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? rem_sub[NUM_W-1:0] : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_nxt;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/gated_contrast_with_hsv_core.sv @@
// top level: rgb to hsv with gated contrast stretch and multiply blend
`default_nettype none

// Takes one 8-bit rgb pixel per clock and returns its hue (whole degrees,
// rounded down), saturation and value, the contrast-stretched channels
// (stretched only when the max channel exceeds the threshold register) and the
// multiply blend of each channel with its stretched form. The block is a
// 14-stage pipeline: five front stages for min/max, numerators, stretch
// products, clamp and blend, then nine stages of two restoring dividers
// (hue and saturation) that retire one quotient bit each. A new pixel is
// taken every clock while the result side keeps up, and any empty stage is
// filled even when the output is stalled. The user must write registers
// through cfg_we/cfg_idx/cfg_data only while no pixel is in flight; the
// block itself does not enforce this.
module gated_contrast_with_hsv_core
	import gcwh_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	gcwh_pix_if.sink                  pix,
	gcwh_res_if.source                res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	logic [GAIN_W-1:0] gain_q;
	logic [CH_W-1:0]   thresh_q;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;

	s1_t pipe_s1;
	s2_t pipe_s2;
	s3_t pipe_s3;
	s4_t pipe_s4;
	s5_t pipe_s5;
	side_t side_s [QUO_W];

	s1_t nxt_s1;
	s2_t nxt_s2;
	s3_t nxt_s3;
	s4_t nxt_s4;
	s5_t nxt_s5;

	logic [QUO_W-1:0] hue_quo;
	logic [QUO_W-1:0] sat_quo;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_THRESH: thresh_q <= cfg_data[CH_W-1:0];
				default:    gain_q   <= gain_q;
			endcase
		end
	end

	// stage can load when empty or when the stage after it moves
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || res.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign pix.ready = rdy[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= pix.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: max, min, delta and hue sector
	always_comb begin
		logic [CH_W-1:0] mn;
		nxt_s1.pix.r = pix.red;
		nxt_s1.pix.g = pix.green;
		nxt_s1.pix.b = pix.blue;
		nxt_s1.mx = pix.red;
		mn = pix.red;
		if (pix.green > nxt_s1.mx) nxt_s1.mx = pix.green;
		if (pix.blue > nxt_s1.mx) nxt_s1.mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		nxt_s1.delta = nxt_s1.mx - mn;
		if (nxt_s1.mx == pix.red) begin
			nxt_s1.sec  = (pix.green >= pix.blue) ? SEC_RED : SEC_RED_WRAP;
			nxt_s1.diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
		end else if (nxt_s1.mx == pix.green) begin
			nxt_s1.sec  = SEC_GREEN;
			nxt_s1.diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
		end else begin
			nxt_s1.sec  = SEC_BLUE;
			nxt_s1.diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) pipe_s1 <= nxt_s1;
	end

	// stage 2: divider operands, brightness gate, stretch products
	always_comb begin
		logic [HUE_W-1:0]          hbase;
		logic [HNUM_W-1:0]         base_term;
		logic signed [HNUM_W:0]    hsum;
		logic signed [PROD_W-1:0]  gain_s;
		logic signed [PROD_W-1:0]  dr;
		logic signed [PROD_W-1:0]  dg;
		logic signed [PROD_W-1:0]  db;
		case (pipe_s1.sec)
			SEC_RED:      hbase = HUE_BASE_RED;
			SEC_RED_WRAP: hbase = HUE_BASE_WRAP;
			SEC_GREEN:    hbase = HUE_BASE_GREEN;
			SEC_BLUE:     hbase = HUE_BASE_BLUE;
			default:      hbase = HUE_BASE_RED;
		endcase
		base_term = HNUM_W'(hbase) * HNUM_W'(pipe_s1.delta);
		hsum = $signed({1'b0, base_term}) + (HNUM_W+1)'(pipe_s1.diff) * HUE_STEP;

		nxt_s2.pix  = pipe_s1.pix;
		nxt_s2.mx   = pipe_s1.mx;
		nxt_s2.gate = (pipe_s1.mx > thresh_q);

		// a grey pixel divides zero by one, a black one too
		if (pipe_s1.delta == '0) begin
			nxt_s2.dop.hue_num = '0;
			nxt_s2.dop.hue_den = CH_W'(1);
		end else begin
			nxt_s2.dop.hue_num = hsum[HNUM_W-1:0];
			nxt_s2.dop.hue_den = pipe_s1.delta;
		end
		nxt_s2.dop.sat_num = {pipe_s1.delta, CH_W'(0)} - SNUM_W'(pipe_s1.delta);
		nxt_s2.dop.sat_den = (pipe_s1.mx == '0) ? CH_W'(1) : pipe_s1.mx;

		// (2x - 255) * gain for each channel
		gain_s = $signed(PROD_W'(gain_q));
		dr = $signed(PROD_W'({pipe_s1.pix.r, 1'b0})) - $signed(PROD_W'(CH_MAX));
		dg = $signed(PROD_W'({pipe_s1.pix.g, 1'b0})) - $signed(PROD_W'(CH_MAX));
		db = $signed(PROD_W'({pipe_s1.pix.b, 1'b0})) - $signed(PROD_W'(CH_MAX));
		nxt_s2.prod_r = dr * gain_s;
		nxt_s2.prod_g = dg * gain_s;
		nxt_s2.prod_b = db * gain_s;
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) pipe_s2 <= nxt_s2;
	end

	// stage 3: offset, scale and clamp, or pass when not bright enough
	always_comb begin
		nxt_s3.pix = pipe_s2.pix;
		nxt_s3.mx  = pipe_s2.mx;
		nxt_s3.dop = pipe_s2.dop;
		if (pipe_s2.gate) begin
			nxt_s3.con.r = stretch_clamp(pipe_s2.prod_r);
			nxt_s3.con.g = stretch_clamp(pipe_s2.prod_g);
			nxt_s3.con.b = stretch_clamp(pipe_s2.prod_b);
		end else begin
			nxt_s3.con = pipe_s2.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) pipe_s3 <= nxt_s3;
	end

	// stage 4: original times contrast
	always_comb begin
		nxt_s4.mx    = pipe_s3.mx;
		nxt_s4.dop   = pipe_s3.dop;
		nxt_s4.con   = pipe_s3.con;
		nxt_s4.mul_r = pipe_s3.pix.r * pipe_s3.con.r;
		nxt_s4.mul_g = pipe_s3.pix.g * pipe_s3.con.g;
		nxt_s4.mul_b = pipe_s3.pix.b * pipe_s3.con.b;
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) pipe_s4 <= nxt_s4;
	end

	// stage 5: blend products over 255
	always_comb begin
		nxt_s5.dop        = pipe_s4.dop;
		nxt_s5.side.con   = pipe_s4.con;
		nxt_s5.side.mx    = pipe_s4.mx;
		nxt_s5.side.bld.r = div255(pipe_s4.mul_r);
		nxt_s5.side.bld.g = div255(pipe_s4.mul_g);
		nxt_s5.side.bld.b = div255(pipe_s4.mul_b);
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) pipe_s5 <= nxt_s5;
	end

	// hue divider: sector numerator over delta
	gcwh_div #(
		.NUM_W (HNUM_W),
		.DEN_W (CH_W),
		.QUO_W (QUO_W)
	) u_hue_div (
		.clk (clk),
		.en  (rdy[NUM_STAGES-1:FRONT_STAGES]),
		.num (pipe_s5.dop.hue_num),
		.den (pipe_s5.dop.hue_den),
		.quo (hue_quo)
	);

	// saturation divider: 255 * delta over max
	gcwh_div #(
		.NUM_W (SNUM_W),
		.DEN_W (CH_W),
		.QUO_W (QUO_W)
	) u_sat_div (
		.clk (clk),
		.en  (rdy[NUM_STAGES-1:FRONT_STAGES]),
		.num (pipe_s5.dop.sat_num),
		.den (pipe_s5.dop.sat_den),
		.quo (sat_quo)
	);

	// finished fields ride next to the divider stages
	always_ff @(posedge clk) begin
		if (rdy[FRONT_STAGES]) begin
			side_s[0] <= pipe_s5.side;
		end
		for (int k = 1; k < QUO_W; k++) begin
			if (rdy[FRONT_STAGES+k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// result item
	assign res.valid          = vld_q[NUM_STAGES-1];
	assign res.contrast_red   = side_s[QUO_W-1].con.r;
	assign res.contrast_green = side_s[QUO_W-1].con.g;
	assign res.contrast_blue  = side_s[QUO_W-1].con.b;
	assign res.blend_red      = side_s[QUO_W-1].bld.r;
	assign res.blend_green    = side_s[QUO_W-1].bld.g;
	assign res.blend_blue     = side_s[QUO_W-1].bld.b;
	assign res.value_level    = side_s[QUO_W-1].mx;
	assign res.hue            = hue_quo;
	assign res.saturation     = sat_quo[CH_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/gcwh_chk.sv @@
// port-level checker for the gated contrast / hsv block and its bind
`default_nettype none

module gcwh_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] contrast_red,
	input wire logic [7:0] contrast_green,
	input wire logic [7:0] contrast_blue,
	input wire logic [7:0] blend_red,
	input wire logic [7:0] blend_green,
	input wire logic [7:0] blend_blue,
	input wire logic [8:0] hue,
	input wire logic [7:0] saturation,
	input wire logic [7:0] value_level
);

	// a stalled result stays offered with the same value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_level) && $stable(hue))
		else $error("result changed while stalled");

	// hue never reaches a full turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> hue <= 9'd359)
		else $error("hue out of range");

	// a black pixel gives zero hue, saturation, contrast channels and red blend
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && value_level == 8'd0 |->
			hue == 9'd0 && saturation == 8'd0 && contrast_red == 8'd0
			&& contrast_green == 8'd0 && contrast_blue == 8'd0 && blend_red == 8'd0)
		else $error("black pixel gave nonzero result");

	// a blend never exceeds its contrast channel
	a_blend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> blend_red <= contrast_red && blend_green <= contrast_green
			&& blend_blue <= contrast_blue)
		else $error("blend above contrast channel");

endmodule

bind gated_contrast_with_hsv_core gcwh_chk u_gcwh_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.contrast_red   (res.contrast_red),
	.contrast_green (res.contrast_green),
	.contrast_blue  (res.contrast_blue),
	.blend_red      (res.blend_red),
	.blend_green    (res.blend_green),
	.blend_blue     (res.blend_blue),
	.hue            (res.hue),
	.saturation     (res.saturation),
	.value_level    (res.value_level)
);

`default_nettype wire

@@ bench/tb_gated_contrast_with_hsv_core.sv @@
// self-checking testbench for the gated contrast / rgb to hsv pixel core
`timescale 1ns / 1ps

module tb_gated_contrast_with_hsv_core
	import gcwh_pkg::*;
();

	localparam int unsigned CLK_HALF    = 6;
	localparam int unsigned RST_CYCLES  = 12;
	localparam int unsigned PIPE_DEPTH  = 14;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned MAX_REPORTS = 60;
	localparam int unsigned N_DIR       = 24;
	localparam int unsigned N_PHASES    = 11;

	// one expected result item
	typedef struct packed {
		rgb_t             con;
		rgb_t             bld;
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_res_t;

	// directed row: pixel, and a hand-typed result where it is obvious
	typedef struct packed {
		rgb_t     px;
		logic     known;
		hsv_res_t want;
	} dir_row_t;

	// register settings and traffic shape of one random phase
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [CH_W-1:0]   thresh;
		logic [6:0]        send_idle;
		logic [6:0]        recv_stall;
		logic              hold;
		logic              shuffle;
	} phase_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_idx;
	logic [CFG_DAT_W-1:0] cfg_data;

	gcwh_pix_if pix_ch();
	gcwh_res_if res_ch();

	gated_contrast_with_hsv_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// directed pixels, run at the reset register values
	dir_row_t dir_rows [N_DIR] = '{
		// black, white and the pure primaries
		'{'{8'd0, 8'd0, 8'd0}, 1'b1,
			'{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, 9'd0, 8'd0, 8'd0}},
		'{'{8'd255, 8'd255, 8'd255}, 1'b1,
			'{'{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, 9'd0, 8'd0, 8'd255}},
		'{'{8'd255, 8'd0, 8'd0}, 1'b1,
			'{'{8'd255, 8'd0, 8'd0}, '{8'd255, 8'd0, 8'd0}, 9'd0, 8'd255, 8'd255}},
		'{'{8'd0, 8'd255, 8'd0}, 1'b1,
			'{'{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd0}, 9'd120, 8'd255, 8'd255}},
		'{'{8'd0, 8'd0, 8'd255}, 1'b1,
			'{'{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd0, 8'd255}, 9'd240, 8'd255, 8'd255}},
		// grey, and pixels on either side of the brightness threshold
		'{'{8'd128, 8'd128, 8'd128}, 1'b0, '0},
		'{'{8'd51, 8'd51, 8'd51}, 1'b0, '0},
		'{'{8'd52, 8'd0, 8'd0}, 1'b0, '0},
		'{'{8'd51, 8'd20, 8'd30}, 1'b0, '0},
		// ties for the max channel
		'{'{8'd200, 8'd200, 8'd10}, 1'b0, '0},
		'{'{8'd10, 8'd200, 8'd200}, 1'b0, '0},
		'{'{8'd200, 8'd10, 8'd200}, 1'b0, '0},
		// red max, wrapped and direct angle
		'{'{8'd250, 8'd10, 8'd100}, 1'b0, '0},
		'{'{8'd250, 8'd100, 8'd10}, 1'b0, '0},
		// green and blue sectors, both slopes
		'{'{8'd30, 8'd240, 8'd90}, 1'b0, '0},
		'{'{8'd90, 8'd240, 8'd30}, 1'b0, '0},
		'{'{8'd30, 8'd90, 8'd240}, 1'b0, '0},
		'{'{8'd90, 8'd30, 8'd240}, 1'b0, '0},
		// near black, near white, alternating bits, around mid-grey
		'{'{8'd1, 8'd0, 8'd0}, 1'b0, '0},
		'{'{8'd0, 8'd0, 8'd1}, 1'b0, '0},
		'{'{8'd255, 8'd254, 8'd253}, 1'b0, '0},
		'{'{8'd170, 8'd85, 8'd240}, 1'b0, '0},
		'{'{8'd85, 8'd170, 8'd15}, 1'b0, '0},
		'{'{8'd127, 8'd128, 8'd129}, 1'b0, '0}
	};

	// gain, threshold, sender idle %, receiver stall %, long hold, random regs
	phase_t phases [N_PHASES] = '{
		'{10'd0,    8'd0,   7'd0,  7'd0,  1'b0, 1'b0},
		'{10'd1023, 8'd0,   7'd54, 7'd0,  1'b0, 1'b0},
		'{10'd1023, 8'd255, 7'd0,  7'd54, 1'b0, 1'b0},
		'{10'd256,  8'd128, 7'd35, 7'd35, 1'b0, 1'b0},
		'{10'd0,    8'd255, 7'd54, 7'd0,  1'b0, 1'b0},
		'{10'd1,    8'd254, 7'd0,  7'd54, 1'b0, 1'b0},
		'{10'd512,  8'd51,  7'd0,  7'd0,  1'b1, 1'b0},
		'{10'd0,    8'd0,   7'd35, 7'd35, 1'b0, 1'b1},
		'{10'd1022, 8'd1,   7'd54, 7'd0,  1'b0, 1'b0},
		'{10'd0,    8'd0,   7'd0,  7'd54, 1'b1, 1'b1},
		'{10'd384,  8'd51,  7'd35, 7'd35, 1'b0, 1'b0}
	};

	// register copies used for prediction
	logic [GAIN_W-1:0] cur_gain;
	logic [CH_W-1:0]   cur_thresh;

	hsv_res_t    pending_q [$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned err_cnt;
	int unsigned sent_cnt;
	int unsigned checked_cnt;
	int unsigned in_stall_cnt;
	int unsigned n_settings;
	int unsigned cycle_cnt;

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// contrast stretch of one channel about mid-grey, clamped
	function automatic logic [CH_W-1:0] stretch_code(input logic [CH_W-1:0] x);
		longint acc;
		acc = (2 * longint'(x) - 255) * longint'(cur_gain) + 65280;
		if (acc < 0)
			return '0;
		acc = acc / 512;
		return (acc > 255) ? CH_MAX : CH_W'(acc);
	endfunction

	// expected result item for one pixel under the current registers
	function automatic hsv_res_t predict_pixel(input rgb_t px);
		hsv_res_t o;
		int r, g, b, mx, mn, delta, num;
		r = int'(px.r);
		g = int'(px.g);
		b = int'(px.b);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		o.hue = '0;
		// red wins ties over green, green over blue
		if (delta != 0) begin
			if (mx == r)
				num = (g >= b) ? 60 * (g - b) : 360 * delta - 60 * (b - g);
			else if (mx == g)
				num = 120 * delta + 60 * (b - r);
			else
				num = 240 * delta + 60 * (r - g);
			o.hue = HUE_W'(num / delta);
		end
		o.sat = (mx != 0) ? CH_W'(255 * delta / mx) : '0;
		o.val = CH_W'(mx);
		o.con = px;
		if (mx > int'(cur_thresh)) begin
			o.con.r = stretch_code(px.r);
			o.con.g = stretch_code(px.g);
			o.con.b = stretch_code(px.b);
		end
		o.bld.r = CH_W'(r * int'(o.con.r) / 255);
		o.bld.g = CH_W'(g * int'(o.con.g) / 255);
		o.bld.b = CH_W'(b * int'(o.con.b) / 255);
		return o;
	endfunction

	// random pixel, biased toward greys, ties, extremes and the threshold
	function automatic rgb_t rand_pixel();
		rgb_t p;
		int   t;
		p.r = 8'($urandom);
		p.g = 8'($urandom);
		p.b = 8'($urandom);
		t = int'(cur_thresh) + int'($urandom_range(4)) - 2;
		if (t < 0) t = 0;
		if (t > 255) t = 255;
		case ($urandom_range(9))
			0: begin
				p.g = p.r;
				p.b = p.r;
			end
			1: p.g = p.r;
			2: p.b = p.g;
			3: p.b = p.r;
			4: begin
				p.r = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
				p.g = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
				p.b = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
			end
			5: begin
				p.r = 8'($urandom_range(t));
				p.g = 8'($urandom_range(t));
				p.b = 8'($urandom_range(t));
				case ($urandom_range(2))
					0: p.r = 8'(t);
					1: p.g = 8'(t);
					default: p.b = 8'(t);
				endcase
			end
			default: ;
		endcase
		return p;
	endfunction

	// offer one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(input rgb_t px, input logic known, input hsv_res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			pix_ch.red   <= 8'($urandom);
			pix_ch.green <= 8'($urandom);
			pix_ch.blue  <= 8'($urandom);
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= px.r;
		pix_ch.green <= px.g;
		pix_ch.blue  <= px.b;
		do @(posedge clk); while (!pix_ch.ready);
		pending_q.push_back(known ? want : predict_pixel(px));
		sent_cnt++;
	endtask

	// stop offering and wait until every result item is back
	task automatic drain_pixels();
		pix_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// write both registers; threshold carries junk in the unused upper bits
	task automatic write_regs(input logic [GAIN_W-1:0] gain, input logic [CH_W-1:0] thresh);
		logic [CFG_DAT_W-1:0] thresh_word;
		thresh_word = {(CFG_DAT_W-CH_W)'($urandom), thresh};
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cur_gain = gain;
		cfg_idx  <= CFG_THRESH;
		cfg_data <= thresh_word;
		@(posedge clk);
		cur_thresh = thresh_word[CH_W-1:0];
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// result side: compare each accepted item
	always @(posedge clk) begin : result_check
		hsv_res_t want;
		if (pix_ch.valid && !pix_ch.ready && arst_n)
			in_stall_cnt++;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: result item with no pixel pending, expected none, actual hue %0d",
						$time, res_ch.hue);
			end else begin
				want = pending_q.pop_front();
				check_field("contrast_red",   want.con.r, res_ch.contrast_red);
				check_field("contrast_green", want.con.g, res_ch.contrast_green);
				check_field("contrast_blue",  want.con.b, res_ch.contrast_blue);
				check_field("blend_red",      want.bld.r, res_ch.blend_red);
				check_field("blend_green",    want.bld.g, res_ch.blend_green);
				check_field("blend_blue",     want.bld.b, res_ch.blend_blue);
				check_field("hue",            want.hue,   res_ch.hue);
				check_field("saturation",     want.sat,   res_ch.saturation);
				check_field("value_level",    want.val,   res_ch.value_level);
				checked_cnt++;
			end
		end
	end

	// receiver ready, with a long hold-off so the pipeline fills and backs up into the input
	initial begin : result_ready
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// run limit
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d result items still pending",
			cycle_cnt, pending_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus: reset, directed rows, then random phases over register settings
	initial begin : stimulus
		phase_t ph;
		int unsigned k;
		int unsigned p;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_idx        <= CFG_GAIN;
		cfg_data       <= '0;
		pix_ch.valid   <= 1'b0;
		pix_ch.red     <= '0;
		pix_ch.green   <= '0;
		pix_ch.blue    <= '0;
		cur_gain       = GAIN_RST;
		cur_thresh     = THRESH_RST;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		hold_left      = 0;
		err_cnt        = 0;
		sent_cnt       = 0;
		checked_cnt    = 0;
		in_stall_cnt   = 0;
		n_settings     = 1;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings, back to back
		for (k = 0; k < N_DIR; k++)
			send_pixel(dir_rows[k].px, dir_rows[k].known, dir_rows[k].want);
		drain_pixels();

		// random phases
		for (p = 0; p < N_PHASES; p++) begin
			ph = phases[p];
			if (ph.shuffle) begin
				ph.gain   = GAIN_W'($urandom);
				ph.thresh = CH_W'($urandom);
			end
			write_regs(ph.gain, ph.thresh);
			send_idle_pct  = ph.send_idle;
			recv_stall_pct = ph.recv_stall;
			if (ph.hold)
				hold_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++)
				send_pixel(rand_pixel(), 1'b0, '0);
			drain_pixels();
		end

		// catch any stray result item after the pipeline empties
		repeat (PIPE_DEPTH + 6) @(posedge clk);
		$display("covered %0d pixels (%0d directed) over %0d register settings, %0d results compared",
			sent_cnt, N_DIR, n_settings, checked_cnt);
		$display("input was held off by the core for %0d cycles", in_stall_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/gcwh_pkg.sv
hw/rtl/gcwh_pix_if.sv
hw/rtl/gcwh_res_if.sv
hw/rtl/gcwh_div.sv
hw/rtl/gated_contrast_with_hsv_core.sv
hw/rtl/gcwh_chk.sv
bench/tb_gated_contrast_with_hsv_core.sv
